[rtl/iff_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the integer field formatter.
// No dependencies; the RTL files refer to this package by scoped names, the bench imports it.
package iff_pkg;

  localparam int unsigned POINTER_BITS_DEF  = 64;
  localparam int unsigned MAX_PRECISION_DEF = 20;

  // Digit register holds up to sixteen nibbles (BCD or hex).
  localparam int unsigned DIGITS_MAX   = 16;
  localparam int unsigned DEC_DIGITS   = 10;
  localparam int unsigned HEX_DIGITS   = 8;
  localparam int unsigned VALUE_BITS   = 32;
  localparam int unsigned DABBLE_STEPS = VALUE_BITS;

  // Conversion codes
  localparam logic [1:0] CONV_SDEC = 2'd0;
  localparam logic [1:0] CONV_UDEC = 2'd1;
  localparam logic [1:0] CONV_HEX  = 2'd2;
  localparam logic [1:0] CONV_PTR  = 2'd3;

  // Sign modes
  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_SPACE = 2'd2;

  // ASCII characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPA   = 8'h41;

  typedef struct packed {
    logic [63:0] number;
    logic [1:0]  conversion;
    logic [5:0]  field_width;
    logic        has_precision;
    logic [5:0]  min_digits;
    logic        left_justify;
    logic [1:0]  sign_mode;
    logic        alt_form;
    logic        zero_pad;
  } in_word_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       error;
  } out_word_t;

  // Emission phases of one field, in output order.
  typedef enum logic [2:0] {
    PH_PRE,
    PH_SIGN,
    PH_ZEROS,
    PH_DIGITS,
    PH_POST
  } phase_e;

  typedef struct packed {
    logic   load;
    logic   convert;
    logic   trim;
    logic   layout;
    logic   emit;
    logic   emit_err;
    phase_e phase;
  } cmd_t;

  typedef struct packed {
    logic in_bad;
    logic in_dec;
    logic conv_done;
    logic trim_more;
    logic rem_zero;
    logic last;
    logic out_free;
    logic pre_zero;
    logic sign_zero;
    logic zeros_zero;
    logic digits_zero;
    logic post_zero;
  } status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] h);
    logic [7:0] c;
    if (h < 4'd10) begin
      c = CH_ZERO + {4'd0, h};
    end else begin
      c = CH_UPA + {4'd0, h - 4'd10};
    end
    return c;
  endfunction

endpackage

[rtl/iff_datapath.sv]
`timescale 1ns / 1ps
// Datapath: captures the item, converts binary to BCD, sizes the field and
// drives the output word register. Depends on iff_pkg.
module iff_datapath #(
  parameter int unsigned POINTER_BITS  = iff_pkg::POINTER_BITS_DEF,
  parameter int unsigned MAX_PRECISION = iff_pkg::MAX_PRECISION_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iff_pkg::in_word_t  in_word_i,
  input  logic               out_stall_i,
  input  iff_pkg::cmd_t      cmd_i,
  output iff_pkg::status_t   status_o,
  output logic               out_valid_o,
  output iff_pkg::out_word_t out_word_o
);

  localparam int unsigned PtrDigits = POINTER_BITS / 4;
  localparam int unsigned PtrSpan   = PtrDigits * 4;

  logic [63:0] dig_q, dig_d;
  logic [31:0] bin_q, bin_d;
  logic [4:0]  step_q, step_d;
  logic [4:0]  nd_q, nd_d;
  logic        is_ptr_q, hp_q, lj_q, zp_q, magzero_q, sign_q, sign_d;
  logic [7:0]  sign_ch_q;
  logic [5:0]  fw_q, md_q;
  logic [5:0]  pre_q, pre_d, zeros_q, zeros_d, post_q, post_d, rem_q, rem_d;
  logic        out_valid_q, out_valid_d;
  iff_pkg::out_word_t out_word_q, out_word_d;

  // Input decode
  logic [31:0] v, mag;
  logic        neg, in_signed;
  logic        in_hp;
  assign v         = in_word_i.number[31:0];
  assign neg       = (in_word_i.conversion == iff_pkg::CONV_SDEC) && v[31];
  assign mag       = neg ? (32'd0 - v) : v;
  assign in_hp     = in_word_i.has_precision;
  assign in_signed = neg || ((in_word_i.conversion != iff_pkg::CONV_PTR) &&
                     ((in_word_i.sign_mode == iff_pkg::SIGN_PLUS) ||
                      (in_word_i.sign_mode == iff_pkg::SIGN_SPACE)));

  // Nibble at the most significant remaining digit
  logic [3:0] top_idx, top_nib;
  assign top_idx = 4'(nd_q - 5'd1);
  assign top_nib = dig_q[top_idx*4 +: 4];

  // Double-dabble adjust of the ten BCD digits
  logic [39:0] adj;
  always_comb begin
    for (int k = 0; k < int'(iff_pkg::DEC_DIGITS); k++) begin
      adj[k*4 +: 4] = (dig_q[k*4 +: 4] >= 4'd5) ? dig_q[k*4 +: 4] + 4'd3
                                                 : dig_q[k*4 +: 4];
    end
  end

  // Field layout
  logic [4:0] nd_eff;
  logic [5:0] lead;
  logic [6:0] content;
  logic [5:0] pad;
  logic       zp_eff;
  always_comb begin
    nd_eff  = (hp_q && (md_q == 6'd0) && magzero_q) ? 5'd0 : nd_q;
    lead    = (hp_q && (md_q > {1'b0, nd_eff})) ? md_q - {1'b0, nd_eff} : 6'd0;
    content = {6'd0, sign_q} + {1'b0, lead} + {2'd0, nd_eff};
    pad     = ({1'b0, fw_q} > content) ? 6'({1'b0, fw_q} - content) : 6'd0;
    zp_eff  = zp_q && !hp_q;
  end

  always_comb begin
    dig_d       = dig_q;
    bin_d       = bin_q;
    step_d      = step_q;
    nd_d        = nd_q;
    sign_d      = sign_q;
    pre_d       = pre_q;
    zeros_d     = zeros_q;
    post_d      = post_q;
    rem_d       = rem_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load) begin
      step_d = 5'd0;
      sign_d = in_signed;
      bin_d  = mag;
      case (in_word_i.conversion)
        iff_pkg::CONV_PTR: begin
          dig_d = 64'(in_word_i.number[PtrSpan-1:0]);
          nd_d  = 5'(PtrDigits);
        end
        iff_pkg::CONV_HEX: begin
          dig_d = {32'd0, mag};
          nd_d  = 5'(iff_pkg::HEX_DIGITS);
        end
        default: begin
          dig_d = 64'd0;
          nd_d  = 5'(iff_pkg::DEC_DIGITS);
        end
      endcase
    end
    if (cmd_i.convert) begin
      dig_d  = {24'd0, adj[38:0], bin_q[31]};
      bin_d  = {bin_q[30:0], 1'b0};
      step_d = step_q + 5'd1;
    end
    if (cmd_i.trim) begin
      nd_d = nd_q - 5'd1;
    end
    if (cmd_i.layout) begin
      nd_d    = nd_eff;
      pre_d   = (!lj_q && !zp_eff) ? pad : 6'd0;
      zeros_d = ((!lj_q && zp_eff) ? pad : 6'd0) + lead;
      post_d  = lj_q ? pad : 6'd0;
      rem_d   = ({1'b0, fw_q} > content) ? fw_q : 6'(content);
    end
    if (cmd_i.emit) begin
      out_valid_d          = 1'b1;
      out_word_d.last      = (rem_q == 6'd1);
      out_word_d.error     = 1'b0;
      out_word_d.character = iff_pkg::CH_SPACE;
      rem_d                = rem_q - 6'd1;
      case (cmd_i.phase)
        iff_pkg::PH_PRE: begin
          pre_d = pre_q - 6'd1;
        end
        iff_pkg::PH_SIGN: begin
          out_word_d.character = sign_ch_q;
          sign_d               = 1'b0;
        end
        iff_pkg::PH_ZEROS: begin
          out_word_d.character = iff_pkg::CH_ZERO;
          zeros_d              = zeros_q - 6'd1;
        end
        iff_pkg::PH_DIGITS: begin
          out_word_d.character = iff_pkg::hex_char(top_nib);
          nd_d                 = nd_q - 5'd1;
        end
        iff_pkg::PH_POST: begin
          post_d = post_q - 6'd1;
        end
        default: begin
          out_word_d.character = iff_pkg::CH_NUL;
        end
      endcase
    end
    if (cmd_i.emit_err) begin
      out_valid_d          = 1'b1;
      out_word_d.character = iff_pkg::CH_NUL;
      out_word_d.last      = 1'b1;
      out_word_d.error     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q      <= dig_d;
    bin_q      <= bin_d;
    step_q     <= step_d;
    nd_q       <= nd_d;
    sign_q     <= sign_d;
    pre_q      <= pre_d;
    zeros_q    <= zeros_d;
    post_q     <= post_d;
    rem_q      <= rem_d;
    out_word_q <= out_word_d;
    if (cmd_i.load) begin
      is_ptr_q  <= (in_word_i.conversion == iff_pkg::CONV_PTR);
      hp_q      <= in_hp;
      md_q      <= in_word_i.min_digits;
      fw_q      <= in_word_i.field_width;
      lj_q      <= in_word_i.left_justify;
      zp_q      <= in_word_i.zero_pad;
      magzero_q <= (mag == 32'd0);
      sign_ch_q <= neg ? iff_pkg::CH_MINUS :
                   (in_word_i.sign_mode == iff_pkg::SIGN_PLUS) ? iff_pkg::CH_PLUS
                                                               : iff_pkg::CH_SPACE;
    end
  end

  always_comb begin
    status_o.in_bad = in_word_i.alt_form ||
                      (in_hp && (in_word_i.min_digits > 6'(MAX_PRECISION))) ||
                      (in_word_i.left_justify && in_word_i.zero_pad) ||
                      ((in_word_i.conversion == iff_pkg::CONV_PTR) &&
                       ((in_word_i.sign_mode != iff_pkg::SIGN_NONE) || in_hp));
    status_o.in_dec = (in_word_i.conversion == iff_pkg::CONV_SDEC) ||
                      (in_word_i.conversion == iff_pkg::CONV_UDEC);
    status_o.conv_done   = (step_q == 5'(iff_pkg::DABBLE_STEPS - 1));
    status_o.trim_more   = !is_ptr_q && (nd_q > 5'd1) && (top_nib == 4'd0);
    status_o.rem_zero    = (rem_q == 6'd0);
    status_o.last        = (rem_q == 6'd1);
    status_o.out_free    = !out_valid_q || !out_stall_i;
    status_o.pre_zero    = (pre_q == 6'd0);
    status_o.sign_zero   = !sign_q;
    status_o.zeros_zero  = (zeros_q == 6'd0);
    status_o.digits_zero = (nd_q == 5'd0);
    status_o.post_zero   = (post_q == 6'd0);
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[rtl/iff_controller.sv]
`timescale 1ns / 1ps
// Controller: sequences capture, conversion, digit trim, layout and the
// character phases of one field, or its error word. Depends on iff_pkg.
module iff_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  iff_pkg::status_t status_i,
  output iff_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERROR,
    S_CONVERT,
    S_TRIM,
    S_LAYOUT,
    S_PRE,
    S_SIGN,
    S_ZEROS,
    S_DIGITS,
    S_POST
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.phase    = iff_pkg::PH_PRE;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (status_i.in_bad) begin
            state_d = S_ERROR;
          end else if (status_i.in_dec) begin
            state_d = S_CONVERT;
          end else begin
            state_d = S_TRIM;
          end
        end
      end
      S_ERROR: begin
        if (status_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_CONVERT: begin
        cmd_o.convert = 1'b1;
        if (status_i.conv_done) begin
          state_d = S_TRIM;
        end
      end
      S_TRIM: begin
        if (status_i.trim_more) begin
          cmd_o.trim = 1'b1;
        end else begin
          state_d = S_LAYOUT;
        end
      end
      S_LAYOUT: begin
        cmd_o.layout = 1'b1;
        state_d      = S_PRE;
      end
      S_PRE: begin
        cmd_o.phase = iff_pkg::PH_PRE;
        if (status_i.rem_zero) begin
          state_d = S_IDLE;
        end else if (status_i.pre_zero) begin
          state_d = S_SIGN;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) state_d = S_IDLE;
        end
      end
      S_SIGN: begin
        cmd_o.phase = iff_pkg::PH_SIGN;
        if (status_i.sign_zero) begin
          state_d = S_ZEROS;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.last ? S_IDLE : S_ZEROS;
        end
      end
      S_ZEROS: begin
        cmd_o.phase = iff_pkg::PH_ZEROS;
        if (status_i.zeros_zero) begin
          state_d = S_DIGITS;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) state_d = S_IDLE;
        end
      end
      S_DIGITS: begin
        cmd_o.phase = iff_pkg::PH_DIGITS;
        if (status_i.digits_zero) begin
          state_d = S_POST;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) state_d = S_IDLE;
        end
      end
      S_POST: begin
        cmd_o.phase = iff_pkg::PH_POST;
        if (status_i.post_zero) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/integer_field_formatter.sv]
`timescale 1ns / 1ps
// Top level of the integer field formatter: controller, datapath, checks.
// Depends on iff_pkg, iff_controller and iff_datapath.

// One input word holds an integer and its printf-style field settings; the
// block answers with the field's ASCII characters, one output word each, the
// final one flagged by last. Invalid settings (alternate form, precision above
// MAX_PRECISION, left justify with zero pad, sign or precision on a pointer)
// give a single word with error and last set and character zero. A precision
// of zero with a zero value and nothing else to print gives no words at all.
// One item is worked at a time. It is captured, converted by shift-and-add-3
// for decimal conversions (not for hex and pointer), stripped of leading zero
// digits (up to 9 for decimal, 7 for hex, none for pointer) until the leading
// digit is found, laid out, and then emitted one character per cycle within
// each character phase while the output is not stalled.
// The last character sits in the output register while the next word is
// already taken.
module integer_field_formatter #(
  parameter int unsigned POINTER_BITS  = iff_pkg::POINTER_BITS_DEF,
  parameter int unsigned MAX_PRECISION = iff_pkg::MAX_PRECISION_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  iff_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output iff_pkg::out_word_t out_word_o
);

  iff_pkg::cmd_t    cmd;
  iff_pkg::status_t status;

  // Sequence the phases of one field
  iff_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold the item, convert, size the field and drive the output word
  iff_datapath #(
    .POINTER_BITS  (POINTER_BITS),
    .MAX_PRECISION (MAX_PRECISION)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  // A captured word blocks the input until its field is done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // Never overwrite an output word that is still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit || cmd.emit_err) |-> (!out_valid_o || !out_stall_i))
    else $error("output word overwritten while stalled");

  // Capture and emission never overlap
  a_no_load_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load && (cmd.emit || cmd.emit_err)))
    else $error("capture during emission");

  // An error word is a lone, final, zero character
  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.error) |->
      (out_word_o.last && (out_word_o.character == iff_pkg::CH_NUL)))
    else $error("malformed error word");

endmodule

[sim/integer_field_formatter_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for integer_field_formatter: directed rows, then random words.
// Depends on iff_pkg and the integer_field_formatter RTL; no files, no arguments.
module integer_field_formatter_tb;
  import iff_pkg::*;

  localparam int unsigned PTR_BITS    = POINTER_BITS_DEF;
  localparam int unsigned MAX_PREC    = MAX_PRECISION_DEF;
  localparam int unsigned MAX_CHARS   = 63;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_WORDS_PER_PHASE = 19;
  localparam int unsigned REPORT_LIMIT = 10;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  // Characters still owed by the block, oldest first.
  out_word_t expected_chars [$];
  int        fail_count  = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct     = 0;

  // Directed rows: "*" means check against the formatter model below,
  // "!" means a single error word, anything else is the literal field text.
  in_word_t  row_words [$];
  string     row_texts [$];

  integer_field_formatter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("integer_field_formatter_tb failed");
      $finish;
    end
  end

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return (d < 4'd10) ? CH_ZERO + 8'(d) : CH_UPA + 8'(d - 4'd10);
  endfunction

  // Format one word the way printf would and queue the characters it owes.
  function automatic void predict_field(input in_word_t w);
    logic [7:0] digits [$];
    logic [7:0] field  [$];
    logic [31:0] mag;
    logic [31:0] radix;
    logic [7:0] sign_ch;
    logic has_sign;
    logic zeros_after_sign;
    logic bad;
    int lead;
    int pad;
    int content;
    int nibbles;
    bad = w.alt_form || (w.has_precision && w.min_digits > MAX_PREC) ||
          (w.left_justify && w.zero_pad) ||
          (w.conversion == CONV_PTR && (w.sign_mode != SIGN_NONE || w.has_precision));
    if (bad) begin
      expected_chars.push_back('{character: CH_NUL, last: 1'b1, error: 1'b1});
      return;
    end
    has_sign = 1'b0;
    sign_ch  = CH_NUL;
    lead     = 0;
    if (w.conversion == CONV_PTR) begin
      // Pointer: always the full nibble count, no sign, no precision.
      nibbles = (PTR_BITS / 4 > 16) ? 16 : PTR_BITS / 4;
      for (int i = nibbles - 1; i >= 0; i--) begin
        digits.push_back(digit_char(4'(w.number >> (4 * i))));
      end
    end else begin
      mag   = w.number[31:0];
      radix = (w.conversion == CONV_HEX) ? 32'd16 : 32'd10;
      if (w.conversion == CONV_SDEC && mag[31]) begin
        // Two's complement negate; the most negative value keeps magnitude 2^31.
        mag      = 32'd0 - mag;
        has_sign = 1'b1;
        sign_ch  = CH_MINUS;
      end else if (w.sign_mode == SIGN_PLUS) begin
        has_sign = 1'b1;
        sign_ch  = CH_PLUS;
      end else if (w.sign_mode == SIGN_SPACE) begin
        has_sign = 1'b1;
        sign_ch  = CH_SPACE;
      end
      // Zero precision with zero value prints no digits at all.
      if (!(w.has_precision && w.min_digits == 6'd0 && mag == 32'd0)) begin
        do begin
          digits.push_front(digit_char(4'(mag % radix)));
          mag = mag / radix;
        end while (mag != 32'd0);
      end
      if (w.has_precision && int'(w.min_digits) > digits.size()) begin
        lead = int'(w.min_digits) - digits.size();
      end
    end
    content = int'(has_sign) + lead + digits.size();
    pad = (int'(w.field_width) > content) ? int'(w.field_width) - content : 0;
    // A precision overrides the zero flag, as in standard printf.
    zeros_after_sign = w.zero_pad && !w.has_precision;
    if (!w.left_justify && !zeros_after_sign) repeat (pad) field.push_back(CH_SPACE);
    if (has_sign) field.push_back(sign_ch);
    if (!w.left_justify && zeros_after_sign) repeat (pad) field.push_back(CH_ZERO);
    repeat (lead) field.push_back(CH_ZERO);
    foreach (digits[i]) field.push_back(digits[i]);
    if (w.left_justify) repeat (pad) field.push_back(CH_SPACE);
    while (field.size() > MAX_CHARS) void'(field.pop_back());
    foreach (field[i]) begin
      expected_chars.push_back('{character: field[i], last: (i == field.size() - 1),
                                 error: 1'b0});
    end
  endfunction

  // Queue a hand-written expectation for a directed row.
  function automatic void queue_text(input string text);
    if (text == "!") begin
      expected_chars.push_back('{character: CH_NUL, last: 1'b1, error: 1'b1});
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        expected_chars.push_back('{character: text[i], last: (i == text.len() - 1),
                                   error: 1'b0});
      end
    end
  endfunction

  function automatic in_word_t field_word(input logic [63:0] number, input logic [1:0] conv,
                                          input int fw, input bit hp, input int md,
                                          input bit lj, input logic [1:0] sm,
                                          input bit alt, input bit zp);
    in_word_t w;
    w.number        = number;
    w.conversion    = conv;
    w.field_width   = 6'(fw);
    w.has_precision = hp;
    w.min_digits    = 6'(md);
    w.left_justify  = lj;
    w.sign_mode     = sm;
    w.alt_form      = alt;
    w.zero_pad      = zp;
    return w;
  endfunction

  function automatic void add_row(input in_word_t w, input string text);
    row_words.push_back(w);
    row_texts.push_back(text);
  endfunction

  // Mostly well-formed settings with random content; one word in six is raw
  // noise, which lands on the error checks and sign mode three.
  function automatic in_word_t random_field();
    in_word_t w;
    logic [95:0] noise;
    noise = {$urandom(), $urandom(), $urandom()};
    w = noise[$bits(in_word_t)-1:0];
    if ($urandom_range(5, 0) == 0) return w;
    case ($urandom_range(9, 0))
      0: w.number[31:0] = 32'h8000_0000;
      1: w.number[31:0] = 32'hFFFF_FFFF;
      2: w.number[31:0] = 32'h7FFF_FFFF;
      3: w.number[31:0] = '0;
      4: w.number[31:0] = $urandom_range(999, 0);
      default: ;
    endcase
    w.field_width = ($urandom_range(4, 0) == 0) ? 6'($urandom_range(63, 0))
                                                : 6'($urandom_range(16, 0));
    w.min_digits  = 6'($urandom_range(MAX_PREC, 0));
    w.sign_mode   = 2'($urandom_range(2, 0));
    w.alt_form    = 1'b0;
    if (w.left_justify) w.zero_pad = 1'b0;
    if (w.conversion == CONV_PTR) begin
      w.sign_mode     = SIGN_NONE;
      w.has_precision = 1'b0;
    end
    return w;
  endfunction

  // Offer one word from a falling edge; return on the falling edge after it is taken.
  task automatic send_word(input in_word_t w, input string text);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (text == "*") predict_field(w);
    else queue_text(text);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every owed character has come out, then let the
  // block settle in case it was working on a word that prints nothing.
  task automatic drain_fields();
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  // Receiver stall, redrawn every cycle at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < stall_pct);
  end

  // Compare each accepted character with the oldest one owed.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < REPORT_LIMIT) begin
          $display("unexpected word: char %h last %b error %b",
                   out_word_o.character, out_word_o.last, out_word_o.error);
        end
      end else begin
        want = expected_chars.pop_front();
        if (out_word_o.character !== want.character || out_word_o.last !== want.last ||
            out_word_o.error !== want.error) begin
          fail_count <= fail_count + 1;
          if (fail_count < REPORT_LIMIT) begin
            $display("mismatch: char exp %h got %h, last exp %b got %b, error exp %b got %b",
                     want.character, out_word_o.character, want.last, out_word_o.last,
                     want.error, out_word_o.error);
          end
        end
      end
    end
  end

  initial begin
    int idle_plan  [4];
    int stall_plan [4];

    idle_plan  = '{0, 88, 0, 20};
    stall_plan = '{0, 0, 88, 20};

    // Extremes of each conversion.
    add_row(field_word(64'd0, CONV_SDEC, 0, 0, 0, 0, SIGN_NONE, 0, 0), "0");
    add_row(field_word(64'h8000_0000, CONV_SDEC, 0, 0, 0, 0, SIGN_NONE, 0, 0), "-2147483648");
    add_row(field_word(64'h7FFF_FFFF, CONV_SDEC, 0, 0, 0, 0, SIGN_NONE, 0, 0), "2147483647");
    add_row(field_word(64'hFFFF_FFFF, CONV_UDEC, 0, 0, 0, 0, SIGN_NONE, 0, 0), "4294967295");
    add_row(field_word(64'hFFFF_FFFF, CONV_HEX, 0, 0, 0, 0, SIGN_NONE, 0, 0), "FFFFFFFF");
    add_row(field_word('1, CONV_PTR, 0, 0, 0, 0, SIGN_NONE, 0, 0), "FFFFFFFFFFFFFFFF");
    add_row(field_word(64'h0123_4567_89AB_CDEF, CONV_PTR, 0, 0, 0, 0, SIGN_NONE, 0, 0),
            "0123456789ABCDEF");
    // Upper half of the number is ignored outside the pointer conversion.
    add_row(field_word(64'hFFFF_FFFF_0000_0001, CONV_SDEC, 0, 0, 0, 0, SIGN_NONE, 0, 0), "1");
    // Each invalid combination.
    add_row(field_word(64'd5, CONV_SDEC, 0, 0, 0, 0, SIGN_NONE, 1, 0), "!");
    add_row(field_word(64'd5, CONV_SDEC, 0, 1, MAX_PREC + 1, 0, SIGN_NONE, 0, 0), "!");
    add_row(field_word(64'd5, CONV_HEX, 4, 0, 0, 1, SIGN_NONE, 0, 1), "!");
    add_row(field_word(64'd5, CONV_PTR, 0, 0, 0, 0, SIGN_PLUS, 0, 0), "!");
    add_row(field_word(64'd5, CONV_PTR, 0, 1, 4, 0, SIGN_NONE, 0, 0), "!");
    add_row(field_word(64'd5, CONV_PTR, 0, 0, 0, 0, 2'd3, 0, 0), "!");
    // Zero precision with zero value: nothing, a lone sign, or only padding.
    add_row(field_word(64'd0, CONV_SDEC, 0, 1, 0, 0, SIGN_NONE, 0, 0), "");
    add_row(field_word(64'd0, CONV_UDEC, 0, 1, 0, 0, SIGN_PLUS, 0, 0), "+");
    add_row(field_word(64'd0, CONV_HEX, 5, 1, 0, 0, SIGN_NONE, 0, 0), "*");
    // Sign modes, including a sign on an unsigned conversion and mode three.
    add_row(field_word(64'd5, CONV_UDEC, 0, 0, 0, 0, SIGN_PLUS, 0, 0), "+5");
    add_row(field_word(64'd42, CONV_SDEC, 0, 0, 0, 0, SIGN_SPACE, 0, 0), " 42");
    add_row(field_word(64'd7, CONV_SDEC, 0, 0, 0, 0, 2'd3, 0, 0), "7");
    // Zero padding, with and without a precision that overrides it.
    add_row(field_word(-64'sd5, CONV_SDEC, 6, 0, 0, 0, SIGN_NONE, 0, 1), "*");
    add_row(field_word(-64'sd5, CONV_SDEC, 8, 1, 3, 0, SIGN_NONE, 0, 1), "*");
    // Widest fields and the largest precision.
    add_row(field_word(64'd1, CONV_SDEC, 63, 0, 0, 1, SIGN_NONE, 0, 0), "*");
    add_row(field_word(64'h8000_0000, CONV_SDEC, 63, 1, MAX_PREC, 0, SIGN_NONE, 0, 0), "*");
    add_row(field_word(64'hBEEF, CONV_HEX, 40, 1, MAX_PREC, 1, SIGN_SPACE, 0, 0), "*");
    add_row(field_word(64'd123, CONV_UDEC, 63, 0, 63, 0, SIGN_NONE, 0, 1), "*");

    // Hold reset, then release it at a falling edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed rows with no idling on either side.
    foreach (row_words[i]) send_word(row_words[i], row_texts[i]);
    drain_fields();

    // Random words under each idling pattern; drain between phases.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      stall_pct     = stall_plan[p];
      for (int n = 0; n < RANDOM_WORDS_PER_PHASE; n++) send_word(random_field(), "*");
      drain_fields();
    end

    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("integer_field_formatter_tb passed");
    end else begin
      $display("integer_field_formatter_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/iff_pkg.sv
rtl/iff_datapath.sv
rtl/iff_controller.sv
rtl/integer_field_formatter.sv
sim/integer_field_formatter_tb.sv
